[rtl/core/dmo_pkg.sv]
// ----------------------------------------------------------------------------
// dmo_pkg: shared types and constants of the multi-waveform oscillator
// Table geometry, waveform codes, register indexes and scale constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dmo_pkg;

  // Wave table geometry.
  localparam int TABLE_DEPTH  = 256;
  localparam int TABLE_COUNT  = 6;
  localparam int STORE_DEPTH  = TABLE_COUNT * TABLE_DEPTH;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int PHASE_W      = 16;
  localparam int SAMPLE_W     = 12;
  localparam int BYTE_W       = 8;
  localparam int SEL_W        = 3;
  localparam int WAVE_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // Item kinds.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 2'd2;

  // Waveform codes; table waveforms follow WAVE_TABLE0 in order.
  localparam logic [WAVE_W-1:0] WAVE_PW_SAW    = 4'd0;
  localparam logic [WAVE_W-1:0] WAVE_PW_SQUARE = 4'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW       = 4'd2;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE    = 4'd3;
  localparam logic [WAVE_W-1:0] WAVE_TABLE0    = 4'd4;

  // Scale constants.
  localparam logic [SAMPLE_W-1:0] MID_SCALE   = 12'd2048;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE  = 12'd4095;
  localparam logic [3:0]          DAC_CMD_A   = 4'h3;
  localparam logic [15:0]         PW_RESET    = 16'd2048;

  // Flat store address of one table entry.
  function automatic logic [STORE_AW-1:0] store_addr(input logic [SEL_W-1:0] tsel,
                                                     input logic [BYTE_W-1:0] tidx);
    logic [31:0] full;
    full = 32'(tsel) * 32'(TABLE_DEPTH) + (32'(tidx) % 32'(TABLE_DEPTH));
    return full[STORE_AW-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/dmo_ram.sv]
// ----------------------------------------------------------------------------
// dmo_ram: generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dmo_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/dmo_wave.sv]
// ----------------------------------------------------------------------------
// dmo_wave: waveform shaper
// Forms the 12-bit sample from the phase, waveform, pulse width and a table byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dmo_wave (
  input  wire logic [dmo_pkg::PHASE_W-1:0]  phase_i,
  input  wire logic [dmo_pkg::WAVE_W-1:0]   waveform_i,
  input  wire logic [15:0]                  pulse_width_i,
  input  wire logic [dmo_pkg::BYTE_W-1:0]   tbl_byte_i,
  output logic      [dmo_pkg::SAMPLE_W-1:0] sample_o
);

  import dmo_pkg::*;

  logic [SAMPLE_W-1:0] s;
  logic [SAMPLE_W-1:0] pw;
  logic [SAMPLE_W-1:0] half;
  logic [SAMPLE_W:0]   s_plus_h;
  logic [SAMPLE_W:0]   mid_plus_h;
  logic                in_window;
  logic                is_table;

  assign s          = phase_i[PHASE_W-1 -: SAMPLE_W];
  assign pw         = pulse_width_i[15 -: SAMPLE_W];
  assign half       = {1'b0, pw[SAMPLE_W-1:1]};
  assign s_plus_h   = {1'b0, s} + {1'b0, half};
  assign mid_plus_h = {1'b0, MID_SCALE} + {1'b0, half};

  // The pulse-width saw is silenced within half the pulse width on either side of mid-scale.
  assign in_window = (s_plus_h > {1'b0, MID_SCALE}) && ({1'b0, s} < mid_plus_h);

  assign is_table = (waveform_i >= WAVE_TABLE0) &&
                    ({1'b0, waveform_i} < ({1'b0, WAVE_TABLE0} + 5'(TABLE_COUNT)));

  // Waveform selection.
  always_comb begin
    sample_o = MID_SCALE;
    case (waveform_i)
      WAVE_PW_SAW:    sample_o = in_window ? '0 : s;
      WAVE_PW_SQUARE: sample_o = (s > pw) ? '0 : FULL_SCALE;
      WAVE_SAW:       sample_o = s;
      WAVE_SQUARE:    sample_o = (s > MID_SCALE) ? '0 : FULL_SCALE;
      default: begin
        if (is_table) begin
          sample_o = {tbl_byte_i, 4'b0000};
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/dds_multiwave_oscillator.sv]
// ----------------------------------------------------------------------------
// dds_multiwave_oscillator: phase-accumulator oscillator with wave tables
// Two-stage pipeline: phase update and table read, then waveform shaping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries either a sample tick or a
//   table entry write, chosen by kind_i. A tick adds the phase step to the
//   16-bit phase and yields one result (sample_o, dac_word_o) on the output
//   channel (out_valid_o / out_stall_i); a table write yields no result.
//   A tick's new phase and table read are registered in the first stage,
//   and its shaped sample in the output register. Throughput is one item
//   per cycle while the receiver does not stall, set by the single RAM
//   port of the wave store, which takes either the tick's table read or one entry write.
//   When the receiver stalls, the result holds in the output register, the
//   stage behind it holds one more tick, and after that in_stall_o rises.
//   Reset clears the phase, the phase step and the waveform, and sets the
//   pulse width to 2048. The wave tables are not cleared: each entry must be
//   written before a tick reads it. The user must write configuration through
//   cfg_we_i only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_multiwave_oscillator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [dmo_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [dmo_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input channel.
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               kind_i,
  input  wire logic [dmo_pkg::SEL_W-1:0]          table_select_i,
  input  wire logic [dmo_pkg::BYTE_W-1:0]         table_index_i,
  input  wire logic [dmo_pkg::BYTE_W-1:0]         table_byte_i,
  // Output channel.
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [dmo_pkg::SAMPLE_W-1:0]       sample_o,
  output logic      [15:0]                        dac_word_o
);

  import dmo_pkg::*;

  logic [PHASE_W-1:0]  phase_step_q;
  logic [WAVE_W-1:0]   waveform_q;
  logic [15:0]         pulse_width_q;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic                s1_valid_q;
  logic [PHASE_W-1:0]  s1_phase_q;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                in_xfer;
  logic                tick_xfer;
  logic                wr_xfer;
  logic                wr_ok;
  logic                out_free;
  logic [SEL_W-1:0]    rd_table;
  logic [STORE_AW-1:0] ram_addr;
  logic [BYTE_W-1:0]   ram_rdata;
  logic [SAMPLE_W-1:0] shaped;

  // Handshake decode.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign tick_xfer  = in_xfer && (kind_i == KIND_TICK);
  assign wr_xfer    = in_xfer && (kind_i == KIND_WRITE);
  assign wr_ok      = (32'(table_select_i) < 32'(TABLE_COUNT)) &&
                      (32'(table_index_i) < 32'(TABLE_DEPTH));

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= '0;
      waveform_q    <= WAVE_PW_SAW;
      pulse_width_q <= PW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PHASE_STEP:  phase_step_q  <= cfg_data_i[PHASE_W-1:0];
        CFG_WAVEFORM:    waveform_q    <= cfg_data_i[WAVE_W-1:0];
        CFG_PULSE_WIDTH: pulse_width_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Phase accumulator, wrapping at 2^16.
  assign phase_d = phase_q + phase_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (tick_xfer) begin
      phase_q <= phase_d;
    end
  end

  // Table address: a write targets its entry, a tick reads at the new phase's top byte.
  assign rd_table = (waveform_q >= WAVE_TABLE0) ? SEL_W'(waveform_q - WAVE_TABLE0) : '0;
  assign ram_addr = wr_xfer ? store_addr(table_select_i, table_index_i)
                            : store_addr(rd_table, phase_d[PHASE_W-1 -: BYTE_W]);

  dmo_ram #(
    .Width (BYTE_W),
    .Depth (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_xfer && wr_ok),
    .re_i    (tick_xfer),
    .addr_i  (ram_addr),
    .wdata_i (table_byte_i),
    .rdata_o (ram_rdata)
  );

  // First stage: the tick's new phase waits beside the table read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= (kind_i == KIND_TICK);
    end else if (out_free) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_xfer) begin
      s1_phase_q <= phase_d;
    end
  end

  dmo_wave u_wave (
    .phase_i       (s1_phase_q),
    .waveform_i    (waveform_q),
    .pulse_width_i (pulse_width_q),
    .tbl_byte_i    (ram_rdata),
    .sample_o      (shaped)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      sample_q <= shaped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign dac_word_o  = {DAC_CMD_A, sample_q};

  // Assertions.
  a_tick_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_xfer |=> s1_valid_q)
    else $error("accepted tick did not enter the first stage");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_xfer |=> !s1_valid_q)
    else $error("table write produced a pipeline entry");

  a_phase_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_xfer |=> $stable(phase_q))
    else $error("phase moved without a tick");

  a_full_pipe_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input taken while both stages were blocked");

endmodule

`default_nettype wire
